// ----- hw/rtl/trilinear_voxel_gather_top_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the trilinear voxel gather block
// ---------------------------------------------------------------------------
`ifndef TRILINEAR_VOXEL_GATHER_TOP_MACROS_SVH
`define TRILINEAR_VOXEL_GATHER_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS
// clocked assertion with async reset disable
`define TVG_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// same, for a condition that must hold at every edge
`define TVG_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`else
`define TVG_ASSERT(lbl, clk, rst_n, prop, msg)
`define TVG_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg)
`endif

`endif

// ----- hw/rtl/trivox_pkg.sv -----
// ---------------------------------------------------------------------------
// trivox_pkg
// Types and constants shared by the trilinear voxel gather block.
// ---------------------------------------------------------------------------
package trivox_pkg;

  localparam int unsigned GridSide    = 16;
  localparam int unsigned Channels    = 4;
  localparam int unsigned FracBits    = 8;
  localparam int unsigned FeatBits    = 16;
  localparam int unsigned CoordBits   = 12;
  localparam int unsigned IdxBits     = 4;
  localparam int unsigned ChBits      = 2;
  localparam int unsigned AddrBits    = ChBits + 3 * IdxBits;
  localparam int unsigned MemDepth    = 1 << AddrBits;
  localparam int unsigned WBits       = FracBits + 1;
  localparam int unsigned ProdBits    = 3 * WBits + 1 + FeatBits;
  localparam int unsigned AccBits     = ProdBits;
  localparam int unsigned CfgIdxBits  = 8;
  localparam int unsigned CfgDataBits = 8;

  localparam logic [CfgIdxBits-1:0] CfgGridSize = CfgIdxBits'(0);
  localparam logic [CfgIdxBits-1:0] CfgChannels = CfgIdxBits'(1);

  typedef struct packed {
    logic                       mode;
    logic [CoordBits-1:0]       point_x;
    logic [CoordBits-1:0]       point_y;
    logic [CoordBits-1:0]       point_z;
    logic [ChBits-1:0]          load_channel;
    logic [IdxBits-1:0]         load_x;
    logic [IdxBits-1:0]         load_y;
    logic [IdxBits-1:0]         load_z;
    logic signed [FeatBits-1:0] load_value;
  } in_item_t;

  typedef struct packed {
    logic signed [FeatBits-1:0] interp_value;
    logic [ChBits-1:0]          channel_index;
    logic                       last_channel;
    logic [IdxBits-1:0]         base_x;
    logic [IdxBits-1:0]         base_y;
    logic [IdxBits-1:0]         base_z;
    logic [FracBits-1:0]        frac_x;
    logic [FracBits-1:0]        frac_y;
    logic [FracBits-1:0]        frac_z;
  } res_item_t;

  // classified work for the back end
  typedef struct packed {
    logic                       is_query;
    logic [IdxBits-1:0]         base_x;
    logic [IdxBits-1:0]         base_y;
    logic [IdxBits-1:0]         base_z;
    logic [IdxBits-1:0]         hi_x;
    logic [IdxBits-1:0]         hi_y;
    logic [IdxBits-1:0]         hi_z;
    logic [FracBits-1:0]        frac_x;
    logic [FracBits-1:0]        frac_y;
    logic [FracBits-1:0]        frac_z;
    logic [ChBits:0]            nch;
    logic [AddrBits-1:0]        ld_addr;
    logic signed [FeatBits-1:0] ld_value;
  } cmd_t;

  typedef struct packed {
    logic idle;
    logic pipe_busy;
    logic draining;
  } bk_stat_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_WAIT,
    BK_ISSUE,
    BK_DRAIN
  } bk_state_e;

endpackage

// ----- hw/rtl/trivox_front.sv -----
// ---------------------------------------------------------------------------
// trivox_front
// Config registers; splits query coordinates into clamped base and fraction.
// ---------------------------------------------------------------------------
module trivox_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  input  logic [trivox_pkg::CfgIdxBits-1:0]   cfg_index_i,
  input  logic [trivox_pkg::CfgDataBits-1:0]  cfg_data_i,
  input  trivox_pkg::in_item_t                item_i,
  output trivox_pkg::cmd_t                    cmd_o
);
  import trivox_pkg::*;

  logic [4:0] gs_q, gs_d;
  logic [2:0] nch_q, nch_d;
  logic [4:0] gs_eff;
  logic [2:0] nch_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gs_q  <= 5'(GridSide);
      nch_q <= 3'(Channels);
    end else begin
      gs_q  <= gs_d;
      nch_q <= nch_d;
    end
  end

  always_comb begin
    gs_d  = gs_q;
    nch_d = nch_q;
    if (cfg_valid_i && cfg_index_i == CfgGridSize) gs_d = cfg_data_i[4:0];
    if (cfg_valid_i && cfg_index_i == CfgChannels) nch_d = cfg_data_i[2:0];
  end

  always_comb begin
    if (gs_q < 5'd2) gs_eff = 5'd2;
    else if (gs_q > 5'(GridSide)) gs_eff = 5'(GridSide);
    else gs_eff = gs_q;
    if (nch_q == 3'd0) nch_eff = 3'd1;
    else if (nch_q > 3'(Channels)) nch_eff = 3'(Channels);
    else nch_eff = nch_q;
  end

  function automatic logic [2*IdxBits+FracBits-1:0] split_axis(
    input logic [CoordBits-1:0] c, input logic [4:0] gs);
    logic [4:0]          b;
    logic [FracBits-1:0] f;
    logic [4:0]          h;
    b = {1'b0, c[CoordBits-1:FracBits]};
    f = c[FracBits-1:0];
    if (b >= gs) begin
      b = gs - 5'd1;
      f = '0;
    end
    h = (b + 5'd1 < gs) ? b + 5'd1 : gs - 5'd1;
    return {b[IdxBits-1:0], h[IdxBits-1:0], f};
  endfunction

  always_comb begin
    cmd_o          = '0;
    cmd_o.is_query = item_i.mode;
    {cmd_o.base_x, cmd_o.hi_x, cmd_o.frac_x} = split_axis(item_i.point_x, gs_eff);
    {cmd_o.base_y, cmd_o.hi_y, cmd_o.frac_y} = split_axis(item_i.point_y, gs_eff);
    {cmd_o.base_z, cmd_o.hi_z, cmd_o.frac_z} = split_axis(item_i.point_z, gs_eff);
    cmd_o.nch      = nch_eff;
    cmd_o.ld_addr  = {item_i.load_channel, item_i.load_x, item_i.load_y, item_i.load_z};
    cmd_o.ld_value = item_i.load_value;
  end

endmodule

// ----- hw/rtl/trivox_cmdq.sv -----
// ---------------------------------------------------------------------------
// trivox_cmdq
// Two-entry command queue between front and back end.
// ---------------------------------------------------------------------------
module trivox_cmdq (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  trivox_pkg::cmd_t cmd_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output trivox_pkg::cmd_t cmd_o
);
  import trivox_pkg::*;

  cmd_t       slot_q [2];
  logic       wr_q, wr_d, rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign cmd_o   = slot_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d  = ~wr_q;
      cnt_d = cnt_d + 2'd1;
    end
    if (pop_i) begin
      rd_d  = ~rd_q;
      cnt_d = cnt_d - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wr_q] <= cmd_i;
  end

endmodule

// ----- hw/rtl/trivox_back.sv -----
// ---------------------------------------------------------------------------
// trivox_back
// Grid memory and corner-serial weighted-sum pipeline, one channel at a time.
// ---------------------------------------------------------------------------
module trivox_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cmd_valid_i,
  input  trivox_pkg::cmd_t      cmd_i,
  output logic                  cmd_pop_o,
  input  logic                  res_pop_i,
  output logic                  res_valid_o,
  output trivox_pkg::res_item_t res_o,
  output trivox_pkg::bk_stat_t  stat_o
);
  import trivox_pkg::*;

  localparam logic [WBits-1:0] One = WBits'(1 << FracBits);

  logic signed [FeatBits-1:0] mem_q [MemDepth];

  bk_state_e state_q, state_d;
  cmd_t      cur_q;
  logic      ld_cur;
  logic [2:0]        k_q, k_d;
  logic [ChBits-1:0] ch_q, ch_d;
  logic      issue, mem_we;

  // pipeline
  logic                       v1_q, v2_q, v3_q, l1_q, l2_q, l3_q;
  logic signed [FeatBits-1:0] rd_q, feat_q;
  logic [2*WBits-1:0]         wxy_q;
  logic [WBits-1:0]           wz_q;
  logic [3*WBits-1:0]         w_q;
  logic signed [ProdBits-1:0] prod_q;
  logic signed [AccBits-1:0]  acc_q, sum;
  logic signed [AccBits-1:0]  rnd;
  logic                       res_valid_q;
  res_item_t                  res_q;
  logic signed [FeatBits-1:0] sat;
  logic                       fin, last_ch;

  logic [WBits-1:0]    wx, wy, wz;
  logic [IdxBits-1:0]  xi, yi, zi;
  logic [AddrBits-1:0] rd_addr;

  always_comb begin
    wx = k_q[2] ? {1'b0, cur_q.frac_x} : One - {1'b0, cur_q.frac_x};
    wy = k_q[1] ? {1'b0, cur_q.frac_y} : One - {1'b0, cur_q.frac_y};
    wz = k_q[0] ? {1'b0, cur_q.frac_z} : One - {1'b0, cur_q.frac_z};
    xi = k_q[2] ? cur_q.hi_x : cur_q.base_x;
    yi = k_q[1] ? cur_q.hi_y : cur_q.base_y;
    zi = k_q[0] ? cur_q.hi_z : cur_q.base_z;
    rd_addr = {ch_q, xi, yi, zi};
  end

  assign fin     = v3_q && l3_q;
  assign last_ch = ({1'b0, ch_q} + 3'd1 == cur_q.nch);

  always_comb begin
    state_d   = state_q;
    k_d       = k_q;
    ch_d      = ch_q;
    cmd_pop_o = 1'b0;
    mem_we    = 1'b0;
    ld_cur    = 1'b0;
    issue     = 1'b0;
    unique case (state_q)
      BK_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          if (cmd_i.is_query) begin
            ld_cur  = 1'b1;
            ch_d    = '0;
            state_d = BK_WAIT;
          end else begin
            mem_we = 1'b1;
          end
        end
      end
      BK_WAIT: begin
        if (!res_valid_q) begin
          k_d     = '0;
          state_d = BK_ISSUE;
        end
      end
      BK_ISSUE: begin
        issue = 1'b1;
        k_d   = k_q + 3'd1;
        if (k_q == 3'd7) state_d = BK_DRAIN;
      end
      BK_DRAIN: begin
        if (fin) begin
          if (last_ch) state_d = BK_IDLE;
          else begin
            ch_d    = ch_q + ChBits'(1);
            state_d = BK_WAIT;
          end
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      k_q         <= '0;
      ch_q        <= '0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      acc_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      ch_q    <= ch_d;
      v1_q    <= issue;
      v2_q    <= v1_q;
      v3_q    <= v2_q;
      if (v3_q) acc_q <= l3_q ? '0 : sum;
      if (fin) res_valid_q <= 1'b1;
      else if (res_pop_i) res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[cmd_i.ld_addr] <= cmd_i.ld_value;
    rd_q <= mem_q[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (ld_cur) cur_q <= cmd_i;
    l1_q   <= (k_q == 3'd7);
    wxy_q  <= wx * wy;
    wz_q   <= wz;
    l2_q   <= l1_q;
    w_q    <= wxy_q * wz_q;
    feat_q <= rd_q;
    l3_q   <= l2_q;
    prod_q <= $signed({1'b0, w_q}) * feat_q;
  end

  // round half up then saturate
  always_comb begin
    sum = acc_q + prod_q;
    rnd = (sum + (AccBits'(1) <<< (3 * FracBits - 1))) >>> (3 * FracBits);
    if (rnd > AccBits'((1 << (FeatBits - 1)) - 1)) sat = {1'b0, {(FeatBits-1){1'b1}}};
    else if (rnd < -(AccBits'(1) <<< (FeatBits - 1))) sat = {1'b1, {(FeatBits-1){1'b0}}};
    else sat = rnd[FeatBits-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (fin) begin
      res_q.interp_value  <= sat;
      res_q.channel_index <= ch_q;
      res_q.last_channel  <= last_ch;
      res_q.base_x        <= cur_q.base_x;
      res_q.base_y        <= cur_q.base_y;
      res_q.base_z        <= cur_q.base_z;
      res_q.frac_x        <= cur_q.frac_x;
      res_q.frac_y        <= cur_q.frac_y;
      res_q.frac_z        <= cur_q.frac_z;
    end
  end

  assign res_valid_o      = res_valid_q;
  assign res_o            = res_q;
  assign stat_o.idle      = (state_q == BK_IDLE);
  assign stat_o.pipe_busy = v1_q | v2_q | v3_q;
  assign stat_o.draining  = (state_q == BK_DRAIN);

endmodule

// ----- hw/rtl/trilinear_voxel_gather_top.sv -----
// A load passes through the command queue and is written to the grid memory
// when the idle back end pops it. A query runs one channel at a time: a wait
// for the previous result to be popped, 8 corner reads from the single grid
// memory port, a 3-stage multiply drain, then the result; no new command is
// taken until the last channel's result is produced.
// Reset: grid_size=16, channels_in_use=4, queues empty; grid contents undefined.
// ---------------------------------------------------------------------------
// trilinear_voxel_gather_top
// Front end splits coordinates, command queue decouples, back end sums corners.
// ---------------------------------------------------------------------------
`include "trilinear_voxel_gather_top_macros.svh"
module trilinear_voxel_gather_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // request channel
  input  logic                                push,
  output logic                                full,
  input  trivox_pkg::in_item_t                in_item_i,
  // result channel
  output logic                                empty,
  input  logic                                pop,
  output trivox_pkg::res_item_t               res_o,
  // config write channel
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [trivox_pkg::CfgIdxBits-1:0]   cfg_index_i,
  input  logic [trivox_pkg::CfgDataBits-1:0]  cfg_data_i
);
  import trivox_pkg::*;

  cmd_t     fe_cmd, q_cmd;
  logic     q_full, q_valid, q_pop;
  logic     res_valid;
  bk_stat_t bk_stat;

  // config is always taken; writes must arrive only while idle, not enforced here
  assign cfg_ready_o = 1'b1;

  trivox_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .item_i      (in_item_i),
    .cmd_o       (fe_cmd)
  );

  // classified requests wait here so the front can keep accepting
  trivox_cmdq u_cmdq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push && !q_full),
    .cmd_i   (fe_cmd),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .cmd_o   (q_cmd)
  );

  trivox_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_valid),
    .cmd_i       (q_cmd),
    .cmd_pop_o   (q_pop),
    .res_pop_i   (pop && res_valid),
    .res_valid_o (res_valid),
    .res_o       (res_o),
    .stat_o      (bk_stat)
  );

  assign full  = q_full;
  assign empty = !res_valid;

  // back end only returns to idle after the multiply pipe has emptied
  `TVG_ASSERT(a_idle_pipe, clk_i, rst_ni, bk_stat.idle |-> !bk_stat.pipe_busy, "pipe busy while idle")
  // a new result only comes out of the drain phase
  `TVG_ASSERT(a_res_src, clk_i, rst_ni, $rose(!empty) |-> $past(bk_stat.draining), "result outside drain")
  // channel 3 is always the last one
  `TVG_ASSERT_ALWAYS(a_last_ch, clk_i, rst_ni, empty || res_o.last_channel || res_o.channel_index != 2'd3, "channel 3 not last")

endmodule
